// ===== rtl/md5_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_pkg
// Shared constants, round tables and controller/datapath interface types
// for the MD5 digest engine.
// ----------------------------------------------------------------------------
package md5_pkg;

    // Longest message, in bytes, that is hashed; later bytes are dropped.
    localparam int MAX_MSG_BYTES = 64;

    // The length counter must hold MAX_MSG_BYTES and always index a 64-byte block.
    localparam int LEN_W = ($clog2(MAX_MSG_BYTES + 1) > 6) ? $clog2(MAX_MSG_BYTES + 1) : 6;

    localparam logic [5:0] RND_LAST  = 6'd63;
    localparam logic [4:0] CHAR_LAST = 5'd31;
    localparam logic [5:0] PAD_SPLIT = 6'd56;
    localparam logic [7:0] PAD_BYTE  = 8'h80;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [31:0] RC_TAB [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] SHIFT_TAB [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef struct packed {
        logic       take;       // input request accepted this cycle
        logic       load;       // copy chaining words into the working registers
        logic       round;      // run one compression round
        logic [5:0] rnd_idx;
        logic       add_chain;  // fold working registers into the chaining words
        logic       pad;        // apply end-of-message padding to the block
        logic       clear_len;  // extra block holding only zeros and the length
        logic       restart;    // digest delivered, return to the initial state
        logic [4:0] char_idx;
    } t_md5_cmd;

    typedef struct packed {
        logic blk_full;  // the offered byte completes a block
        logic pad_two;   // padding spills into a second block
    } t_md5_stat;

endpackage

// ===== rtl/md5_digest_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_digest_engine
// MD5 digest of a byte stream, delivered as 32 lowercase hex characters.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one request per message byte: tdata is the byte,
//   tuser says the byte is present, tlast ends the message. A request with
//   tuser low and tlast high ends a message without adding a byte.
//   The master channel returns 32 ASCII hex characters per message, digest
//   bytes low first, high nibble first; tlast marks the 32nd character and
//   tuser flags a message whose bytes beyond the length limit were dropped.
// Timing:
//   A byte that does not complete a 64-byte block is taken without a compression
//   pass. A byte that completes a block starts a pass of 64 rounds through the
//   single round unit, after which the result is folded into the chaining words;
//   no request is taken during the pass and the fold. The last request adds
//   a padding pass, or two passes when the padding spills into a second
//   block, and then the characters follow at one per cycle while the
//   receiver is ready. A receiver stall holds the current character;
//   s_axis_tready stays low until the last character is taken.
// Reset:
//   Synchronous, active low. Clears the chaining words, the length and the
//   overflow flag; the engine then waits for the first byte.
// ----------------------------------------------------------------------------
module md5_digest_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] msg_byte
    input  logic       s_axis_tuser,   // [0] has_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [6:0] hex_char, [7] zero
    output logic       m_axis_tuser,   // [0] too_long
    output logic       m_axis_tlast
);
    import md5_pkg::*;

    t_md5_cmd  w_cmd;
    t_md5_stat w_stat;
    logic [6:0] w_hex_char;

    md5_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    md5_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_msg_byte  (s_axis_tdata),
        .i_has_byte  (s_axis_tuser),
        .o_hex_char  (w_hex_char),
        .o_char_last (m_axis_tlast),
        .o_too_long  (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, w_hex_char};

    // Intake and digest delivery never overlap.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a digest is being delivered");

    // Taking the final character reopens the input channel.
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("input not reopened after the final character");

    // The last round of a pass is always followed by the chaining update.
    a_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.round && (w_cmd.rnd_idx == RND_LAST)) |=> w_cmd.add_chain)
        else $error("compression pass not folded into chaining words");

    // Characters are decimal digits or lowercase a through f.
    a_hex_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata >= 8'h30 && m_axis_tdata <= 8'h39) ||
                           (m_axis_tdata >= 8'h61 && m_axis_tdata <= 8'h66)))
        else $error("digest character outside the hex alphabet");

endmodule

// ===== rtl/md5_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_ctrl
// Sequencer for the MD5 engine: byte intake, 64-round compression passes,
// padding passes and delivery of the 32 hex characters.
// ----------------------------------------------------------------------------
module md5_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  md5_pkg::t_md5_stat i_stat,
    output md5_pkg::t_md5_cmd  o_cmd
);
    import md5_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROUND = 3'd1;
    localparam logic [2:0] S_ADD   = 3'd2;
    localparam logic [2:0] S_PAD   = 3'd3;
    localparam logic [2:0] S_CLEAR = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    // Where to go once a compression pass has been folded in.
    localparam logic [1:0] POST_IDLE  = 2'd0;
    localparam logic [1:0] POST_PAD   = 2'd1;
    localparam logic [1:0] POST_CLEAR = 2'd2;
    localparam logic [1:0] POST_EMIT  = 2'd3;

    logic [2:0] r_state, n_state;
    logic [1:0] r_post, n_post;
    logic [5:0] r_rnd, n_rnd;
    logic [4:0] r_char, n_char;

    always_comb begin
        n_state     = r_state;
        n_post      = r_post;
        n_rnd       = r_rnd;
        n_char      = r_char;
        o_cmd       = '0;
        o_cmd.rnd_idx  = r_rnd;
        o_cmd.char_idx = r_char;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_stat.blk_full) begin
                        o_cmd.load = 1'b1;
                        n_rnd      = '0;
                        n_post     = i_in_last ? POST_PAD : POST_IDLE;
                        n_state    = S_ROUND;
                    end else if (i_in_last) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_rnd       = r_rnd + 6'd1;
                if (r_rnd == RND_LAST) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add_chain = 1'b1;
                unique case (r_post)
                    POST_IDLE:  n_state = S_IDLE;
                    POST_PAD:   n_state = S_PAD;
                    POST_CLEAR: n_state = S_CLEAR;
                    POST_EMIT:  n_state = S_EMIT;
                    default:    n_state = S_IDLE;
                endcase
            end
            S_PAD: begin
                o_cmd.pad  = 1'b1;
                o_cmd.load = 1'b1;
                n_rnd      = '0;
                n_post     = i_stat.pad_two ? POST_CLEAR : POST_EMIT;
                n_state    = S_ROUND;
            end
            S_CLEAR: begin
                o_cmd.clear_len = 1'b1;
                o_cmd.load      = 1'b1;
                n_rnd           = '0;
                n_post          = POST_EMIT;
                n_state         = S_ROUND;
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_char = r_char + 5'd1;
                    if (r_char == CHAR_LAST) begin
                        o_cmd.restart = 1'b1;
                        n_state       = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_post  <= POST_IDLE;
            r_rnd   <= '0;
            r_char  <= '0;
        end else begin
            r_state <= n_state;
            r_post  <= n_post;
            r_rnd   <= n_rnd;
            r_char  <= n_char;
        end
    end

endmodule

// ===== rtl/md5_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_dp
// MD5 datapath: message block, length and overflow tracking, one shared
// compression round unit, chaining words and hex character output.
// ----------------------------------------------------------------------------
module md5_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  md5_pkg::t_md5_cmd  i_cmd,
    output md5_pkg::t_md5_stat o_stat,
    input  logic [7:0]        i_msg_byte,
    input  logic              i_has_byte,
    output logic [6:0]        o_hex_char,
    output logic              o_char_last,
    output logic              o_too_long
);
    import md5_pkg::*;

    logic [31:0]      r_blk [16];
    logic [31:0]      r_chain [4];
    logic [31:0]      r_a, r_b, r_c, r_d;
    logic [LEN_W-1:0] r_len;
    logic             r_ovf;

    logic        w_room;
    logic [5:0]  w_pos;
    logic [31:0] w_len_bits;

    assign w_room     = (r_len < LEN_W'(MAX_MSG_BYTES));
    assign w_pos      = r_len[5:0];
    assign w_len_bits = 32'({r_len, 3'b000});

    assign o_stat.blk_full = i_has_byte && w_room && (w_pos == 6'd63);
    assign o_stat.pad_two  = (w_pos >= PAD_SPLIT);

    // One compression round.
    logic [1:0]  w_phase;
    logic [3:0]  w_q;
    logic [3:0]  w_g;
    logic [31:0] w_f;
    logic [31:0] w_sum;
    logic [63:0] w_rot;
    logic [31:0] w_t;

    assign w_phase = i_cmd.rnd_idx[5:4];
    assign w_q     = i_cmd.rnd_idx[3:0];

    always_comb begin
        case (w_phase)
            2'd0: begin
                w_g = w_q;
                w_f = (r_b & r_c) | (~r_b & r_d);
            end
            2'd1: begin
                w_g = 4'(4'd5 * w_q + 4'd1);
                w_f = (r_d & r_b) | (~r_d & r_c);
            end
            2'd2: begin
                w_g = 4'(4'd3 * w_q + 4'd5);
                w_f = r_b ^ r_c ^ r_d;
            end
            default: begin
                w_g = 4'(4'd7 * w_q);
                w_f = r_c ^ (r_b | ~r_d);
            end
        endcase
    end

    assign w_sum = r_a + w_f + RC_TAB[i_cmd.rnd_idx] + r_blk[w_g];
    // Rotate left by shifting a doubled copy and keeping the upper half.
    assign w_rot = {w_sum, w_sum} << SHIFT_TAB[{w_phase, w_q[1:0]}];
    assign w_t   = r_b + w_rot[63:32];

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
        end else if (i_cmd.round) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= w_t;
        end
    end

    // Chaining words, length and overflow flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_chain[0] <= IV_A;
            r_chain[1] <= IV_B;
            r_chain[2] <= IV_C;
            r_chain[3] <= IV_D;
            r_len      <= '0;
            r_ovf      <= 1'b0;
        end else begin
            if (i_cmd.add_chain) begin
                r_chain[0] <= r_chain[0] + r_a;
                r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c;
                r_chain[3] <= r_chain[3] + r_d;
            end
            if (i_cmd.take && i_has_byte) begin
                if (w_room) begin
                    r_len <= r_len + LEN_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end

    // Message block. Bytes land little-endian; the first byte of a word
    // clears the rest of that word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_has_byte && w_room) begin
            if (w_pos[1:0] == 2'd0) begin
                r_blk[w_pos[5:2]] <= {24'd0, i_msg_byte};
            end else begin
                r_blk[w_pos[5:2]][w_pos[1:0]*8 +: 8] <= i_msg_byte;
            end
        end else if (i_cmd.pad) begin
            for (int w = 0; w < 16; w++) begin
                for (int l = 0; l < 4; l++) begin
                    // When the padding fits, the last two words carry the length.
                    if (w >= 14 && w_pos < PAD_SPLIT) begin
                        r_blk[w][l*8 +: 8] <= (w == 14) ? w_len_bits[l*8 +: 8] : 8'd0;
                    end else if (6'(w * 4 + l) == w_pos) begin
                        r_blk[w][l*8 +: 8] <= PAD_BYTE;
                    end else if (6'(w * 4 + l) > w_pos) begin
                        r_blk[w][l*8 +: 8] <= 8'd0;
                    end
                end
            end
        end else if (i_cmd.clear_len) begin
            for (int w = 0; w < 16; w++) begin
                r_blk[w] <= (w == 14) ? w_len_bits : 32'd0;
            end
        end
    end

    // Hex output: digest bytes low first, high nibble first within a byte.
    logic [3:0]  w_k;
    logic [31:0] w_word;
    logic [7:0]  w_byte;
    logic [3:0]  w_nib;

    assign w_k    = i_cmd.char_idx[4:1];
    assign w_word = r_chain[w_k[3:2]];
    assign w_byte = w_word[w_k[1:0]*8 +: 8];
    assign w_nib  = i_cmd.char_idx[0] ? w_byte[3:0] : w_byte[7:4];

    assign o_hex_char  = (w_nib < 4'd10) ? (7'h30 + 7'(w_nib)) : (7'h57 + 7'(w_nib));
    assign o_char_last = (i_cmd.char_idx == CHAR_LAST);
    assign o_too_long  = r_ovf;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for md5_digest_engine. Byte requests are streamed in
// with random pacing. A local MD5 model predicts the 32 hex characters of
// every digest, and each character taken from the master side is compared
// with the oldest prediction. Directed messages, the padding boundaries
// around one block, the length limit and random messages are covered.
// ----------------------------------------------------------------------------
module testbench;

    import md5_pkg::*;

    typedef struct packed {
        logic [6:0] hex;
        logic       last;
        logic       too_long;
    } t_hex_char;

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    localparam int ROUND_SHIFT [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };
    localparam int WORD_STRIDE [4] = '{1, 5, 3, 7};
    localparam int WORD_OFFSET [4] = '{0, 1, 5, 0};
    localparam logic [7:0] PAD_MARK    = 8'h80;
    localparam int         BLOCK_BYTES = 64;
    localparam int         ITEM_TARGET = 250;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] msg_byte
    logic       s_axis_tuser = 1'b0;    // [0] has_byte
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [6:0] hex_char, [7] zero
    logic       m_axis_tuser;           // [0] too_long
    logic       m_axis_tlast;

    md5_digest_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Local hash state.
    logic [31:0] msg_words [16];
    logic [31:0] digest_state [4];
    int unsigned bytes_taken;
    logic        bytes_dropped;

    t_hex_char digest_chars_due [$];

    bit sender_paced = 1'b1;
    bit sink_paced = 1'b1;
    int sink_wait = 0;
    int mismatches = 0;
    int chars_checked = 0;
    int digests_due = 0;
    int overflow_msgs = 0;
    int bytes_requested = 0;
    int items_sent = 0;

    function automatic logic [31:0] rotate_left(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic void md5_restart();
        digest_state[0] = 32'h67452301;
        digest_state[1] = 32'hefcdab89;
        digest_state[2] = 32'h98badcfe;
        digest_state[3] = 32'h10325476;
        bytes_taken = 0;
        bytes_dropped = 1'b0;
    endfunction

    function automatic void md5_compress();
        logic [31:0] a, b, c, d, f, t;
        int phase, q, g;
        a = digest_state[0];
        b = digest_state[1];
        c = digest_state[2];
        d = digest_state[3];
        for (int i = 0; i < 64; i++) begin
            phase = i >> 4;
            q = i & 15;
            g = (WORD_STRIDE[phase] * q + WORD_OFFSET[phase]) & 15;
            case (phase)
                0: f = (b & c) | (~b & d);
                1: f = (d & b) | (~d & c);
                2: f = b ^ c ^ d;
                default: f = c ^ (b | ~d);
            endcase
            t = b + rotate_left(a + f + ROUND_CONST[i] + msg_words[g],
                                ROUND_SHIFT[(phase << 2) | (q & 3)]);
            a = d;
            d = c;
            c = b;
            b = t;
        end
        digest_state[0] += a;
        digest_state[1] += b;
        digest_state[2] += c;
        digest_state[3] += d;
    endfunction

    // Bytes land little-endian; the first byte of a word clears the rest of it.
    function automatic void md5_put_byte(input int pos, input logic [7:0] value);
        int w, sh;
        w = (pos >> 2) & 15;
        sh = (pos & 3) * 8;
        if (sh == 0) begin
            msg_words[w] = {24'h0, value};
        end else begin
            msg_words[w][sh +: 8] = value;
        end
    endfunction

    function automatic void md5_finish();
        string digits;
        int pos;
        logic [7:0] b;
        digits = "0123456789abcdef";
        pos = bytes_taken & 63;
        md5_put_byte(pos, PAD_MARK);
        for (int i = pos + 1; i < BLOCK_BYTES; i++) md5_put_byte(i, 8'h00);
        // No room for the length word: it goes into an extra block.
        if (pos >= 56) begin
            md5_compress();
            foreach (msg_words[i]) msg_words[i] = 32'h0;
        end
        msg_words[14] = bytes_taken << 3;
        msg_words[15] = 32'h0;
        md5_compress();
        for (int k = 0; k < 16; k++) begin
            b = digest_state[k >> 2][(k & 3) * 8 +: 8];
            digest_chars_due.push_back('{7'(digits[b[7:4]]), 1'b0, bytes_dropped});
            digest_chars_due.push_back('{7'(digits[b[3:0]]), k == 15, bytes_dropped});
        end
        digests_due++;
        if (bytes_dropped) overflow_msgs++;
        md5_restart();
    endfunction

    function automatic void md5_absorb(input logic [7:0] value, input logic has,
                                       input logic fin);
        int pos;
        if (has) begin
            if (bytes_taken < MAX_MSG_BYTES) begin
                pos = bytes_taken & 63;
                md5_put_byte(pos, value);
                bytes_taken++;
                if (pos == 63) md5_compress();
            end else begin
                bytes_dropped = 1'b1;
            end
        end
        if (fin) md5_finish();
    endfunction

    // The result side: random stalls, and each character checked in order.
    always @(posedge i_clk) begin
        int w;
        t_hex_char want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_wait <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            chars_checked++;
            if (digest_chars_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: unexpected character %h last %b flag %b", $realtime,
                             m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end
            end else begin
                want = digest_chars_due.pop_front();
                if (m_axis_tdata !== {1'b0, want.hex} || m_axis_tlast !== want.last ||
                    m_axis_tuser !== want.too_long) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: expected %h last %b flag %b, got %h last %b flag %b",
                                 $realtime, {1'b0, want.hex}, want.last, want.too_long,
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    end
                end
            end
            w = sink_paced ? $urandom_range(0, 4) : 0;
            m_axis_tready <= (w == 0);
            sink_wait <= w;
        end else if (!m_axis_tready) begin
            if (sink_wait <= 1) m_axis_tready <= 1'b1;
            sink_wait <= sink_wait - 1;
        end
    end

    // Leaves the request up after acceptance so that a back-to-back request
    // needs only one assignment in that step.
    task automatic send_item(input logic [7:0] value, input logic has, input logic fin);
        int gap;
        gap = sender_paced ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= value;
        s_axis_tuser <= has;
        s_axis_tlast <= fin;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (has) bytes_requested++;
        items_sent++;
        md5_absorb(value, has, fin);
    endtask

    task automatic wait_digests_drained();
        s_axis_tvalid <= 1'b0;
        while (digest_chars_due.size() != 0) @(posedge i_clk);
    endtask

    // Random bytes with the odd empty non-final request mixed in; the message
    // ends either on its last byte or on an extra empty request.
    task automatic send_message(input int n_bytes);
        bit end_on_byte;
        end_on_byte = (n_bytes > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < n_bytes; i++) begin
            if ($urandom_range(0, 15) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == n_bytes - 1));
        end
        if (!end_on_byte) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic test_directed_messages();
        sender_paced = 1'b1;
        sink_paced = 1'b1;
        send_item(8'h00, 1'b0, 1'b1);
        // Hold off until the empty-message digest is fully out.
        wait_digests_drained();
        send_item(8'hff, 1'b0, 1'b0);
        send_item("a", 1'b1, 1'b0);
        send_item("b", 1'b1, 1'b0);
        send_item("c", 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h5a, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
    endtask

    // 55 bytes pad in one block, 56 spill into a second.
    task automatic test_block_boundaries();
        int sizes [2] = '{55, 56};
        foreach (sizes[i]) begin
            sender_paced = $urandom_range(0, 2) != 0;
            sink_paced = $urandom_range(0, 2) != 0;
            send_message(sizes[i]);
        end
    endtask

    // The long message also fills and compresses one whole block.
    task automatic test_length_limit();
        sender_paced = 1'b1;
        sink_paced = 1'b0;
        send_message(MAX_MSG_BYTES + $urandom_range(1, 3));
        // The next digest must come without the flag.
        send_message($urandom_range(1, 4));
    endtask

    task automatic test_random_messages();
        int msgs;
        msgs = 0;
        while (items_sent < ITEM_TARGET || msgs < 2) begin
            sender_paced = $urandom_range(0, 3) != 0;
            sink_paced = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 3) == 0) begin
                send_message($urandom_range(0, MAX_MSG_BYTES + 4));
            end else begin
                send_message($urandom_range(0, 12));
            end
            msgs++;
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_messages();
        test_block_boundaries();
        test_length_limit();
        test_random_messages();
        wait_digests_drained();
        // Allow for a padding pass that should not have been started.
        repeat (200) @(posedge i_clk);
        $display("Hashed %0d messages from %0d requests and %0d bytes, %0d over the limit.",
                 digests_due, items_sent, bytes_requested, overflow_msgs);
        $display("Checked %0d hex characters, %0d mismatches.", chars_checked, mismatches);
        if (mismatches == 0 && digest_chars_due.size() == 0) begin
            $display("PASS md5_digest_engine");
        end else begin
            $display("FAIL md5_digest_engine");
        end
        $finish;
    end

    initial begin
        md5_restart();
        foreach (msg_words[i]) msg_words[i] = 32'h0;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d characters outstanding.", digest_chars_due.size());
        $display("FAIL md5_digest_engine");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/md5_pkg.sv
rtl/md5_ctrl.sv
rtl/md5_dp.sv
rtl/md5_digest_engine.sv
bench/testbench.sv
